FILE: src/i2c_master_write_sequencer_core_macros.svh
// ----------------------------------------------------------------------------
// I2C master write sequencer assertion macros
// Concurrent assertion helpers for the sequencer core. Synthesis gets empty
// bodies.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_WRITE_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define I2CMWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define I2CMWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CMWS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define I2CMWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/i2cmws_pkg.sv
// ----------------------------------------------------------------------------
// I2C master write sequencer package
// Transaction payload types, phase codes and fixed constants.
// ----------------------------------------------------------------------------
package i2cmws_pkg;

    typedef struct packed {
        logic       req_type;
        logic       send_start;
        logic       send_addr;
        logic       send_data;
        logic       send_stop;
        logic [6:0] slave_addr;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_released;
        logic       busy_res;
        logic [1:0] status;
    } t_out_item;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_ST_C    = 4'd3;
    localparam logic [3:0] PH_AB_LO   = 4'd4;
    localparam logic [3:0] PH_AB_HI   = 4'd5;
    localparam logic [3:0] PH_AB_TAIL = 4'd6;
    localparam logic [3:0] PH_AACK_LO = 4'd7;
    localparam logic [3:0] PH_AACK_HI = 4'd8;
    localparam logic [3:0] PH_DB_LO   = 4'd9;
    localparam logic [3:0] PH_DB_HI   = 4'd10;
    localparam logic [3:0] PH_DACK_LO = 4'd11;
    localparam logic [3:0] PH_DACK_HI = 4'd12;
    localparam logic [3:0] PH_SP_A    = 4'd13;
    localparam logic [3:0] PH_SP_B    = 4'd14;
    localparam logic [3:0] PH_SP_C    = 4'd15;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_ADDR_NACK = 2'd2;
    localparam logic [1:0] ST_DATA_NACK = 2'd3;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;
    localparam logic [2:0]  TOP_BIT           = 3'd7;
    localparam logic        REG_PHASE_TICKS   = 1'b0;

endpackage

FILE: src/i2cmws_in_if.sv
// ----------------------------------------------------------------------------
// I2C master write sequencer input channel
// Valid/ready channel that carries one tick transaction with its command.
// ----------------------------------------------------------------------------
interface i2cmws_in_if import i2cmws_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/i2cmws_out_if.sv
// ----------------------------------------------------------------------------
// I2C master write sequencer output channel
// Valid/ready channel that carries the line levels and status of one tick.
// ----------------------------------------------------------------------------
interface i2cmws_out_if import i2cmws_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/i2c_master_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master write sequencer core
// Bit-bang sequencer for a 7-bit address write: start, address with ACK,
// one data byte with ACK and stop, each optional, one tick per input transaction.
//
// Channel   Direction  Handshake       Payload
// i_in      in         valid / ready   command fields and sampled SDA
// o_out     out        valid / ready   SCL, SDA, release, busy, status
// APB       in         psel / penable  phase_ticks at byte address 0
//
// Every input transaction yields one output transaction in the next cycle.
// A new transaction is taken in every cycle while the output register is
// empty or being emptied, so the rate is one per clock without stalls.
// The sequencer state and the output register are updated in the same edge.
// Reset is synchronous and active low and leaves the bus idle with both
// lines high.
// ----------------------------------------------------------------------------
`include "i2c_master_write_sequencer_core_macros.svh"

module i2c_master_write_sequencer_core import i2cmws_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    i2cmws_in_if.sink           i_in,
    i2cmws_out_if.source        o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0] r_phase_ticks;
    logic [3:0]  r_phase;
    logic [3:0]  r_bit_count;
    logic [15:0] r_tick_count;
    logic [7:0]  r_shift_byte;
    logic [7:0]  r_held_data;
    logic [1:0]  r_pending;
    logic        r_scl;
    logic        r_sda;
    logic        r_rel;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [3:0]  n_phase;
    logic [3:0]  n_bit_count;
    logic [15:0] n_tick_count;
    logic [7:0]  n_shift_byte;
    logic [7:0]  n_held_data;
    logic [1:0]  n_pending;
    logic        n_scl;
    logic        n_sda;
    logic        n_rel;
    logic [1:0]  n_status;

    logic        in_accept;
    logic        cfg_write;
    logic [15:0] limit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PHASE_TICKS);
    assign prdata    = (paddr[2] == REG_PHASE_TICKS) ? {16'd0, r_phase_ticks} : 32'd0;
    assign limit     = (r_phase_ticks == 16'd0) ? 16'd1 : r_phase_ticks;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        logic        ent_addr;
        logic        ent_data;
        logic        ent_stop;
        logic        addr_flag;
        logic [3:0]  bc_inc;
        logic [15:0] tick_inc;

        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_tick_count = r_tick_count;
        n_shift_byte = r_shift_byte;
        n_held_data  = r_held_data;
        n_pending    = r_pending;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_rel        = r_rel;
        n_status     = ST_NONE;
        ent_addr     = 1'b0;
        ent_data     = 1'b0;
        ent_stop     = 1'b0;
        addr_flag    = 1'b0;
        bc_inc       = r_bit_count + 4'd1;
        tick_inc     = r_tick_count + 16'd1;

        if (r_phase == PH_IDLE) begin
            if (i_in.data.req_type) begin
                n_held_data  = i_in.data.data_byte;
                n_shift_byte = {i_in.data.slave_addr, 1'b0};
                n_pending    = {i_in.data.send_stop, i_in.data.send_data};
                n_tick_count = 16'd0;
                if (i_in.data.send_start) begin
                    n_phase     = PH_ST_A;
                    n_bit_count = {3'd0, i_in.data.send_addr};
                    n_scl       = 1'b1;
                    n_sda       = 1'b1;
                    n_rel       = 1'b0;
                end else begin
                    ent_addr  = 1'b1;
                    addr_flag = i_in.data.send_addr;
                end
            end
        end else if (tick_inc < limit) begin
            n_tick_count = tick_inc;
        end else begin
            n_tick_count = 16'd0;
            case (r_phase)
                PH_ST_A: begin
                    n_phase = PH_ST_B;
                    n_sda   = 1'b0;
                    n_rel   = 1'b0;
                end
                PH_ST_B: begin
                    n_phase = PH_ST_C;
                    n_scl   = 1'b0;
                    n_rel   = 1'b0;
                end
                PH_ST_C: begin
                    ent_addr  = 1'b1;
                    addr_flag = r_bit_count[0];
                end
                PH_AB_LO: begin
                    n_phase = PH_AB_HI;
                    n_scl   = 1'b1;
                    n_rel   = 1'b0;
                end
                PH_AB_HI: begin
                    n_bit_count = bc_inc;
                    n_scl       = 1'b0;
                    n_rel       = 1'b0;
                    if (bc_inc < 4'd8) begin
                        n_phase = PH_AB_LO;
                        n_sda   = r_shift_byte[TOP_BIT - bc_inc[2:0]];
                    end else begin
                        n_phase = PH_AB_TAIL;
                    end
                end
                PH_AB_TAIL: begin
                    n_phase = PH_AACK_LO;
                    n_scl   = 1'b0;
                    n_sda   = 1'b1;
                    n_rel   = 1'b1;
                end
                PH_AACK_LO: begin
                    n_phase = PH_AACK_HI;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_rel   = 1'b1;
                end
                PH_AACK_HI: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                    n_rel = 1'b1;
                    if (i_in.data.sda_in) begin
                        n_phase     = PH_IDLE;
                        n_bit_count = 4'd0;
                        n_status    = ST_ADDR_NACK;
                    end else begin
                        ent_data = 1'b1;
                    end
                end
                PH_DB_LO: begin
                    n_phase = PH_DB_HI;
                    n_scl   = 1'b1;
                    n_rel   = 1'b0;
                end
                PH_DB_HI: begin
                    n_bit_count = bc_inc;
                    n_scl       = 1'b0;
                    if (bc_inc < 4'd8) begin
                        n_phase = PH_DB_LO;
                        n_sda   = r_held_data[TOP_BIT - bc_inc[2:0]];
                        n_rel   = 1'b0;
                    end else begin
                        n_phase = PH_DACK_LO;
                        n_sda   = 1'b1;
                        n_rel   = 1'b1;
                    end
                end
                PH_DACK_LO: begin
                    n_phase = PH_DACK_HI;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_rel   = 1'b1;
                end
                PH_DACK_HI: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                    n_rel = 1'b1;
                    if (i_in.data.sda_in) begin
                        n_phase     = PH_IDLE;
                        n_bit_count = 4'd0;
                        n_status    = ST_DATA_NACK;
                    end else begin
                        ent_stop = 1'b1;
                    end
                end
                PH_SP_A: begin
                    n_phase = PH_SP_B;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                    n_rel   = 1'b0;
                end
                PH_SP_B: begin
                    n_phase = PH_SP_C;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_rel   = 1'b0;
                end
                PH_SP_C: begin
                    n_phase     = PH_IDLE;
                    n_bit_count = 4'd0;
                    n_status    = ST_DONE;
                end
                default: begin
                    n_phase     = PH_IDLE;
                    n_bit_count = 4'd0;
                    n_status    = ST_NONE;
                end
            endcase
        end

        // The command parts are entered in order, skipping those not asked for.
        if (ent_addr) begin
            if (addr_flag) begin
                n_phase     = PH_AB_LO;
                n_bit_count = 4'd0;
                n_scl       = 1'b0;
                n_sda       = n_shift_byte[TOP_BIT];
                n_rel       = 1'b0;
            end else begin
                ent_data = 1'b1;
            end
        end
        if (ent_data) begin
            if (n_pending[0]) begin
                n_phase     = PH_DB_LO;
                n_bit_count = 4'd0;
                n_scl       = 1'b0;
                n_sda       = n_held_data[TOP_BIT];
                n_rel       = 1'b0;
            end else begin
                ent_stop = 1'b1;
            end
        end
        if (ent_stop) begin
            if (n_pending[1]) begin
                n_phase = PH_SP_A;
                n_scl   = 1'b0;
                n_sda   = 1'b0;
                n_rel   = 1'b0;
            end else begin
                n_phase      = PH_IDLE;
                n_bit_count  = 4'd0;
                n_tick_count = 16'd0;
                n_status     = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (cfg_write) begin
            r_phase_ticks <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_tick_count <= 16'd0;
            r_shift_byte <= 8'd0;
            r_held_data  <= 8'd0;
            r_pending    <= 2'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_rel        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_tick_count <= n_tick_count;
            r_shift_byte <= n_shift_byte;
            r_held_data  <= n_held_data;
            r_pending    <= n_pending;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_rel        <= n_rel;
            r_out_valid  <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out.scl_out      <= n_scl;
            r_out.sda_out      <= n_sda;
            r_out.sda_released <= n_rel;
            r_out.busy_res     <= (n_phase != PH_IDLE);
            r_out.status       <= n_status;
        end
    end

    `I2CMWS_ASSERT_SAME(a_released_sda_high, i_clk, i_rst_n, r_out_valid && r_out.sda_released, r_out.sda_out, "Released SDA is not reported high.")
    `I2CMWS_ASSERT_SAME(a_status_only_at_end, i_clk, i_rst_n, r_out_valid && (r_out.status != ST_NONE), !r_out.busy_res, "Status reported while still busy.")
    `I2CMWS_ASSERT_SAME(a_idle_tick_clear, i_clk, i_rst_n, r_phase == PH_IDLE, r_tick_count == 16'd0, "Tick counter not cleared while idle.")
    `I2CMWS_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, in_accept, r_out_valid, "Accepted transaction produced no result.")

endmodule
